// ===== design/ata_pkg.sv =====
// Shared types and constants for the target adjustment pipeline.
`timescale 1ns / 1ps
package ata_pkg;

    // divider: quotient bits resolved per stage and stage count
    localparam int unsigned DIV_WIDTH  = 64;
    localparam int unsigned DIV_STEPS  = 4;
    localparam int unsigned DIV_STAGES = DIV_WIDTH / DIV_STEPS;

    // register map (index = paddr[5:3])
    localparam logic [2:0] REG_SPACING   = 3'd0;
    localparam logic [2:0] REG_HALF_LIFE = 3'd1;
    localparam logic [2:0] REG_LIMIT0    = 3'd2;
    localparam logic [2:0] REG_LIMIT1    = 3'd3;
    localparam logic [2:0] REG_LIMIT2    = 3'd4;
    localparam logic [2:0] REG_LIMIT3    = 3'd5;

    localparam logic [31:0] SPACING_RST   = 32'd600;
    localparam logic [31:0] HALF_LIFE_RST = 32'd172800;
    localparam logic [63:0] LIMIT_LO_RST  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIMIT_HI_RST  = 64'h0000_0000_FFFF_FFFF;

    // cubic approximation of 2^x on x in [0,1) scaled by 2^16
    localparam logic [47:0] POLY_C1    = 48'd195766423245049;
    localparam logic [29:0] POLY_C2    = 30'd971821376;
    localparam logic [12:0] POLY_C3    = 13'd5127;
    localparam logic [63:0] POLY_ROUND = 64'h0000_8000_0000_0000;
    localparam logic [16:0] FACTOR_ONE = 17'h10000;

    localparam logic [46:0] DRIFT_MAX  = 47'h7FFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_RAISED  = 2'd1,
        ST_LIMITED = 2'd2
    } t_clamp;

    typedef struct packed {
        logic [31:0]  spacing;
        logic [31:0]  half_life;
        logic [255:0] limit;
    } t_cfg;

    typedef struct packed {
        logic [255:0] ref_target;
        logic         bad;
        logic         nneg;
    } t_div_side;

    typedef struct packed {
        logic       left;
        logic       rzero;
        logic [8:0] amt;
        logic [8:0] sl;
    } t_shctl;

    typedef struct packed {
        logic [255:0] ref_target;
        logic         bad;
        t_shctl       sh;
    } t_mul_side;

endpackage

// ===== design/asert_target_adjust_unit.sv =====
// Top level of the exponential target adjustment pipeline.
`timescale 1ns / 1ps
// Throughput: one transfer per cycle; busy is tied low and the receiver cannot stall.
// The depth is set by the 64-bit exponent divider (16 stages, 4 quotient bits each).
// Synchronous active-low reset clears all valid bits and loads register defaults.
module asert_target_adjust_unit import ata_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [63:0]        i_ref_target_w0,
    input  logic [63:0]        i_ref_target_w1,
    input  logic [63:0]        i_ref_target_w2,
    input  logic [63:0]        i_ref_target_w3,
    input  logic signed [63:0] i_time_diff,
    input  logic [30:0]        i_height_diff,
    output logic               o_done,
    output logic [63:0]        o_next_w0,
    output logic [63:0]        o_next_w1,
    output logic [63:0]        o_next_w2,
    output logic [63:0]        o_next_w3,
    output logic [1:0]         o_clamp_status,
    output logic               o_bad_input,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    t_cfg cfg;

    ata_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // every stage advances each cycle, so a new transfer is always taken
    assign busy = 1'b0;

    // stage 1: spacing * height, reference target range check
    logic         r_s1_v;
    logic [255:0] r_s1_ref;
    logic [63:0]  r_s1_t;
    logic [62:0]  r_s1_p;
    logic         r_s1_bad;
    logic [255:0] in_ref;

    assign in_ref = {i_ref_target_w3, i_ref_target_w2, i_ref_target_w1, i_ref_target_w0};

    // stage 2: drift in sign/magnitude, saturated to the drift bound
    logic         r_s2_v;
    logic [255:0] r_s2_ref;
    logic         r_s2_dneg;
    logic [46:0]  r_s2_dmag;
    logic         r_s2_bad;
    logic         n_dneg;
    logic [63:0]  dmag_full;
    logic [63:0]  p_ext;

    assign p_ext = {1'b0, r_s1_p};

    always_comb begin
        if (!r_s1_t[63]) begin
            if (r_s1_t >= p_ext) begin
                n_dneg    = 1'b0;
                dmag_full = r_s1_t - p_ext;
            end else begin
                n_dneg    = 1'b1;
                dmag_full = p_ext - r_s1_t;
            end
        end else begin
            n_dneg    = 1'b1;
            dmag_full = (~r_s1_t + 64'd1) + p_ext;
        end
    end

    // stage 3: subtract one more spacing (height + 1)
    logic         r_s3_v;
    logic         r_s3_nneg;
    logic [47:0]  r_s3_nmag;
    logic [255:0] r_s3_ref;
    logic         r_s3_bad;
    logic         n_nneg;
    logic [47:0]  n_nmag;
    logic [47:0]  sp_ext;
    logic [47:0]  dm_ext;

    assign sp_ext = {16'd0, cfg.spacing};
    assign dm_ext = {1'b0, r_s2_dmag};

    always_comb begin
        if (r_s2_dneg) begin
            n_nneg = 1'b1;
            n_nmag = dm_ext + sp_ext;
        end else if (dm_ext >= sp_ext) begin
            n_nneg = 1'b0;
            n_nmag = dm_ext - sp_ext;
        end else begin
            n_nneg = 1'b1;
            n_nmag = sp_ext - dm_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ref <= in_ref;
        r_s1_t   <= i_time_diff;
        r_s1_p   <= cfg.spacing * i_height_diff;
        r_s1_bad <= (in_ref == 256'd0) || (in_ref > cfg.limit);

        r_s2_ref  <= r_s1_ref;
        r_s2_dneg <= n_dneg;
        if (dmag_full > {17'd0, DRIFT_MAX}) begin
            r_s2_dmag <= DRIFT_MAX;
            r_s2_bad  <= 1'b1;
        end else begin
            r_s2_dmag <= dmag_full[46:0];
            r_s2_bad  <= r_s1_bad;
        end

        r_s3_ref  <= r_s2_ref;
        r_s3_bad  <= r_s2_bad;
        r_s3_nneg <= n_nneg;
        r_s3_nmag <= n_nmag;
    end

    // exponent quotient: (n << 16) / half_life, zero half-life counts as one
    logic        div_v;
    logic [63:0] div_q;
    t_div_side   div_in_side;
    t_div_side   div_out_side;
    logic [31:0] divisor;

    assign divisor                 = (cfg.half_life == 32'd0) ? 32'd1 : cfg.half_life;
    assign div_in_side.ref_target  = r_s3_ref;
    assign div_in_side.bad         = r_s3_bad;
    assign div_in_side.nneg        = r_s3_nneg;

    ata_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_s3_v),
        .i_dividend ({r_s3_nmag, 16'd0}),
        .i_divisor  (divisor),
        .i_side     (div_in_side),
        .o_valid    (div_v),
        .o_quot     (div_q),
        .o_side     (div_out_side)
    );

    // 2^frac factor and shift control
    logic        pow_v;
    logic [16:0] pow_factor;
    t_mul_side   pow_side;

    ata_pow u_pow (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_v),
        .i_quot   (div_q),
        .i_side   (div_out_side),
        .o_valid  (pow_v),
        .o_factor (pow_factor),
        .o_side   (pow_side)
    );

    // scale, shift, clamp; the last stage is the output register
    logic [255:0] next_val;
    t_clamp       status;

    ata_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (pow_v),
        .i_factor (pow_factor),
        .i_side   (pow_side),
        .i_limit  (cfg.limit),
        .o_valid  (o_done),
        .o_next   (next_val),
        .o_status (status),
        .o_bad    (o_bad_input)
    );

    assign o_next_w0      = next_val[63:0];
    assign o_next_w1      = next_val[127:64];
    assign o_next_w2      = next_val[191:128];
    assign o_next_w3      = next_val[255:192];
    assign o_clamp_status = status;

endmodule

// ===== design/ata_cfg.sv =====
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps
module ata_cfg import ata_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [31:0] r_spacing;
    logic [31:0] r_half_life;
    logic [63:0] r_limit_w0;
    logic [63:0] r_limit_w1;
    logic [63:0] r_limit_w2;
    logic [63:0] r_limit_w3;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing   <= SPACING_RST;
            r_half_life <= HALF_LIFE_RST;
            r_limit_w0  <= LIMIT_LO_RST;
            r_limit_w1  <= LIMIT_LO_RST;
            r_limit_w2  <= LIMIT_LO_RST;
            r_limit_w3  <= LIMIT_HI_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[5:3])
                REG_SPACING:   r_spacing   <= pwdata[31:0];
                REG_HALF_LIFE: r_half_life <= pwdata[31:0];
                REG_LIMIT0:    r_limit_w0  <= pwdata;
                REG_LIMIT1:    r_limit_w1  <= pwdata;
                REG_LIMIT2:    r_limit_w2  <= pwdata;
                REG_LIMIT3:    r_limit_w3  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[5:3])
            REG_SPACING:   prdata = {32'd0, r_spacing};
            REG_HALF_LIFE: prdata = {32'd0, r_half_life};
            REG_LIMIT0:    prdata = r_limit_w0;
            REG_LIMIT1:    prdata = r_limit_w1;
            REG_LIMIT2:    prdata = r_limit_w2;
            REG_LIMIT3:    prdata = r_limit_w3;
            default:       prdata = 64'd0;
        endcase
    end

    assign o_cfg.spacing   = r_spacing;
    assign o_cfg.half_life = r_half_life;
    assign o_cfg.limit     = {r_limit_w3, r_limit_w2, r_limit_w1, r_limit_w0};

endmodule

// ===== design/ata_div.sv =====
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
`timescale 1ns / 1ps
module ata_div import ata_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [DIV_WIDTH-1:0] i_dividend,
    input  logic [31:0]          i_divisor,
    input  t_div_side            i_side,
    output logic                 o_valid,
    output logic [DIV_WIDTH-1:0] o_quot,
    output t_div_side            o_side
);

    logic [DIV_STAGES-1:0] r_v;
    logic [DIV_WIDTH-1:0]  r_nq   [DIV_STAGES];
    logic [31:0]           r_rem  [DIV_STAGES];
    t_div_side             r_side [DIV_STAGES];

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        logic                 v_in;
        logic [DIV_WIDTH-1:0] nq_in;
        logic [31:0]          rem_in;
        t_div_side            side_in;
        logic [DIV_WIDTH-1:0] n_nq;
        logic [31:0]          n_rem;

        if (g == 0) begin : g_first
            assign v_in    = i_valid;
            assign nq_in   = i_dividend;
            assign rem_in  = 32'd0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[g-1];
            assign nq_in   = r_nq[g-1];
            assign rem_in  = r_rem[g-1];
            assign side_in = r_side[g-1];
        end

        // nq holds unconsumed dividend bits on top, quotient bits shifted in below
        always_comb begin
            logic [32:0] trial;
            n_nq  = nq_in;
            n_rem = rem_in;
            trial = 33'd0;
            for (int k = 0; k < DIV_STEPS; k++) begin
                trial = {n_rem, n_nq[DIV_WIDTH-1]};
                n_nq  = {n_nq[DIV_WIDTH-2:0], 1'b0};
                if (trial >= {1'b0, i_divisor}) begin
                    trial   = trial - {1'b0, i_divisor};
                    n_nq[0] = 1'b1;
                end
                n_rem = trial[31:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else begin
                r_v[g] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_nq[g]   <= n_nq;
            r_rem[g]  <= n_rem;
            r_side[g] <= side_in;
        end
    end

    assign o_valid = r_v[DIV_STAGES-1];
    assign o_quot  = r_nq[DIV_STAGES-1];
    assign o_side  = r_side[DIV_STAGES-1];

endmodule

// ===== design/ata_pow.sv =====
// Exponent split and pipelined cubic evaluation of the 2^frac factor.
`timescale 1ns / 1ps
module ata_pow import ata_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [63:0] i_quot,
    input  t_div_side   i_side,
    output logic        o_valid,
    output logic [16:0] o_factor,
    output t_mul_side   o_side
);

    // split stage
    logic               r_sf_v;
    logic signed [49:0] r_sf_shifts;
    logic [15:0]        r_sf_frac;
    logic [255:0]       r_sf_ref;
    logic               r_sf_bad;
    logic signed [49:0] n_sf_shifts;
    logic [15:0]        n_sf_frac;

    always_comb begin
        if (!i_side.nneg || i_quot == 64'd0) begin
            n_sf_shifts = $signed({2'b00, i_quot[63:16]});
            n_sf_frac   = i_quot[15:0];
        end else if (i_quot[15:0] == 16'd0) begin
            n_sf_shifts = -$signed({2'b00, i_quot[63:16]});
            n_sf_frac   = 16'd0;
        end else begin
            n_sf_shifts = -$signed({2'b00, i_quot[63:16]}) - 50'sd1;
            n_sf_frac   = ~i_quot[15:0] + 16'd1;
        end
    end

    // stage 1: first products, shift control
    logic               r_p1_v;
    logic [63:0]        r_p1_t1;
    logic [31:0]        r_p1_f2;
    logic [15:0]        r_p1_frac;
    t_mul_side          r_p1_side;
    logic signed [50:0] s_val;
    logic [50:0]        s_neg;
    t_shctl             n_sh;

    always_comb begin
        s_val      = $signed({r_sf_shifts[49], r_sf_shifts}) - 51'sd16;
        s_neg      = 51'(-s_val);
        n_sh.left  = !s_val[50] && (s_val != 51'sd0);
        n_sh.rzero = !n_sh.left && (s_neg >= 51'd320);
        n_sh.amt   = n_sh.left ? s_val[8:0] : s_neg[8:0];
        n_sh.sl    = (s_val > 51'sd256) ? 9'd257 : s_val[8:0];
    end

    // stage 2 / 3 / 4
    logic        r_p2_v;
    logic [63:0] r_p2_t1;
    logic [61:0] r_p2_t2;
    logic [47:0] r_p2_f3;
    t_mul_side   r_p2_side;
    logic        r_p3_v;
    logic [63:0] r_p3_t1;
    logic [61:0] r_p3_t2;
    logic [60:0] r_p3_t3;
    t_mul_side   r_p3_side;
    logic        r_p4_v;
    logic [16:0] r_p4_factor;
    t_mul_side   r_p4_side;
    logic [63:0] poly_sum;

    // sum wraps at 64 bits like the reference arithmetic
    assign poly_sum = r_p3_t1 + {2'b00, r_p3_t2} + {3'b000, r_p3_t3} + POLY_ROUND;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf_v <= 1'b0;
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else begin
            r_sf_v <= i_valid;
            r_p1_v <= r_sf_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sf_shifts <= n_sf_shifts;
        r_sf_frac   <= n_sf_frac;
        r_sf_ref    <= i_side.ref_target;
        r_sf_bad    <= i_side.bad;

        r_p1_t1              <= POLY_C1 * r_sf_frac;
        r_p1_f2              <= r_sf_frac * r_sf_frac;
        r_p1_frac            <= r_sf_frac;
        r_p1_side.ref_target <= r_sf_ref;
        r_p1_side.bad        <= r_sf_bad;
        r_p1_side.sh         <= n_sh;

        r_p2_t1   <= r_p1_t1;
        r_p2_t2   <= POLY_C2 * r_p1_f2;
        r_p2_f3   <= r_p1_f2 * r_p1_frac;
        r_p2_side <= r_p1_side;

        r_p3_t1   <= r_p2_t1;
        r_p3_t2   <= r_p2_t2;
        r_p3_t3   <= POLY_C3 * r_p2_f3;
        r_p3_side <= r_p2_side;

        r_p4_factor <= FACTOR_ONE + {1'b0, poly_sum[63:48]};
        r_p4_side   <= r_p3_side;
    end

    assign o_valid  = r_p4_v;
    assign o_factor = r_p4_factor;
    assign o_side   = r_p4_side;

endmodule

// ===== design/ata_mul.sv =====
// Target times factor, two-step barrel shift, overflow and clamp.
`timescale 1ns / 1ps
module ata_mul import ata_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [16:0]  i_factor,
    input  t_mul_side    i_side,
    input  logic [255:0] i_limit,
    output logic         o_valid,
    output logic [255:0] o_next,
    output t_clamp       o_status,
    output logic         o_bad
);

    // partial products, 32-bit chunks of the target
    logic        r_m1_v;
    logic [48:0] r_m1_pp [8];
    t_mul_side   r_m1_side;

    // sum
    logic         r_m2_v;
    logic [319:0] r_m2_val;
    t_mul_side    r_m2_side;
    logic [319:0] pp_even;
    logic [319:0] pp_odd;

    always_comb begin
        pp_even = '0;
        pp_odd  = '0;
        for (int j = 0; j < 4; j++) begin
            pp_even[64*j +: 49]    = r_m1_pp[2*j];
            pp_odd[64*j+32 +: 49]  = r_m1_pp[2*j+1];
        end
    end

    // overflow detect
    logic         r_m3_v;
    logic [319:0] r_m3_val;
    logic         r_m3_ovf;
    logic         r_m3_left;
    logic [8:0]   r_m3_amt;
    logic         r_m3_bad;
    logic [319:0] ovf_mask;

    always_comb begin
        for (int i = 0; i < 320; i++) begin
            ovf_mask[i] = ((10'(i) + {1'b0, r_m2_side.sh.sl}) >= 10'd256);
        end
    end

    // coarse and fine shift
    logic         r_m4_v;
    logic [319:0] r_m4_val;
    logic         r_m4_ovf;
    logic         r_m4_left;
    logic [4:0]   r_m4_amt;
    logic         r_m4_bad;
    logic         r_m5_v;
    logic [319:0] r_m5_val;
    logic         r_m5_ovf;
    logic         r_m5_bad;

    // clamp
    logic         r_out_v;
    logic [255:0] r_out_next;
    t_clamp       r_out_status;
    logic         r_out_bad;
    logic [255:0] base;
    logic [255:0] n_next;
    t_clamp       n_status;

    always_comb begin
        if (r_m5_ovf || (r_m5_val[319:256] != 64'd0)) begin
            base     = i_limit;
            n_status = ST_LIMITED;
        end else begin
            base     = r_m5_val[255:0];
            n_status = ST_NONE;
        end
        if (base == 256'd0) begin
            n_next   = 256'd1;
            n_status = ST_RAISED;
        end else if (base > i_limit) begin
            n_next   = i_limit;
            n_status = ST_LIMITED;
        end else begin
            n_next   = base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_m3_v  <= 1'b0;
            r_m4_v  <= 1'b0;
            r_m5_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_m1_v  <= i_valid;
            r_m2_v  <= r_m1_v;
            r_m3_v  <= r_m2_v;
            r_m4_v  <= r_m3_v;
            r_m5_v  <= r_m4_v;
            r_out_v <= r_m5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            r_m1_pp[j] <= i_side.ref_target[32*j +: 32] * i_factor;
        end
        r_m1_side <= i_side;

        r_m2_val  <= pp_even + pp_odd;
        r_m2_side <= r_m1_side;

        r_m3_val  <= r_m2_side.sh.rzero ? 320'd0 : r_m2_val;
        r_m3_ovf  <= r_m2_side.sh.left && (|(r_m2_val & ovf_mask));
        r_m3_left <= r_m2_side.sh.left;
        r_m3_amt  <= r_m2_side.sh.amt;
        r_m3_bad  <= r_m2_side.bad;

        r_m4_val  <= r_m3_left ? (r_m3_val << {r_m3_amt[8:5], 5'd0})
                               : (r_m3_val >> {r_m3_amt[8:5], 5'd0});
        r_m4_ovf  <= r_m3_ovf;
        r_m4_left <= r_m3_left;
        r_m4_amt  <= r_m3_amt[4:0];
        r_m4_bad  <= r_m3_bad;

        r_m5_val  <= r_m4_left ? (r_m4_val << r_m4_amt) : (r_m4_val >> r_m4_amt);
        r_m5_ovf  <= r_m4_ovf;
        r_m5_bad  <= r_m4_bad;

        r_out_next   <= n_next;
        r_out_status <= n_status;
        r_out_bad    <= r_m5_bad;
    end

    assign o_valid  = r_out_v;
    assign o_next   = r_out_next;
    assign o_status = r_out_status;
    assign o_bad    = r_out_bad;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the exponential target adjustment unit.
`timescale 1ns / 1ps
module testbench import ata_pkg::*; ();

    // polynomial terms held at 64 bits so the sum wraps the same way the pipeline's does
    localparam logic [63:0] K_C1    = 64'd195766423245049;
    localparam logic [63:0] K_C2    = 64'd971821376;
    localparam logic [63:0] K_C3    = 64'd5127;
    localparam logic [63:0] K_ROUND = 64'h0000_8000_0000_0000;
    localparam logic [63:0] K_BOUND = 64'h0000_8000_0000_0000;
    localparam int          WDOG_MAX = 4000;
    localparam int          DRAIN    = 40;     // pipeline is 30 deep
    localparam logic [255:0] LIM_RST = {LIMIT_HI_RST, LIMIT_LO_RST, LIMIT_LO_RST, LIMIT_LO_RST};

    typedef struct {
        logic [255:0] target;
        logic [63:0]  tdiff;
        logic [30:0]  height;
    } t_adj_req;

    typedef struct {
        logic [255:0] next;
        t_clamp       status;
        logic         bad;
    } t_adj_res;

    typedef struct {
        t_adj_req req;
        bit       typed;
        t_adj_res res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [63:0] i_ref_target_w0 = '0, i_ref_target_w1 = '0;
    logic [63:0] i_ref_target_w2 = '0, i_ref_target_w3 = '0;
    logic signed [63:0] i_time_diff = '0;
    logic [30:0] i_height_diff = '0;
    logic        o_done;
    logic [63:0] o_next_w0, o_next_w1, o_next_w2, o_next_w3;
    logic [1:0]  o_clamp_status;
    logic        o_bad_input;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    // configuration as the unit should hold it
    logic [31:0]  spacing_q;
    logic [31:0]  half_life_q;
    logic [255:0] limit_q;

    t_adj_res pending_targets[$];
    int       errors = 0;
    int       idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    asert_target_adjust_unit u_dut (.*);

    // next target for one request under the current register settings
    function automatic t_adj_res adjust_target(t_adj_req rq);
        logic [63:0]  prod, dmag, nmag, q, hl, frac, factor;
        logic         dneg, nneg, bad;
        longint       shifts;
        logic [319:0] val;
        logic [255:0] res;
        int           bl;
        t_clamp       st;
        t_adj_res     r;
        st   = ST_NONE;
        bad  = (rq.target == '0) || (rq.target > limit_q);
        prod = {32'd0, spacing_q} * {33'd0, rq.height};
        // drift = time - spacing * height, as sign and magnitude
        if (!rq.tdiff[63]) begin
            if (rq.tdiff >= prod) begin
                dneg = 1'b0; dmag = rq.tdiff - prod;
            end else begin
                dneg = 1'b1; dmag = prod - rq.tdiff;
            end
        end else begin
            dneg = 1'b1; dmag = (~rq.tdiff + 64'd1) + prod;
        end
        if (dmag >= K_BOUND) begin
            bad = 1'b1; dmag = K_BOUND - 64'd1;
        end
        if (dneg) begin
            nneg = 1'b1; nmag = dmag + spacing_q;
        end else if (dmag >= spacing_q) begin
            nneg = 1'b0; nmag = dmag - spacing_q;
        end else begin
            nneg = 1'b1; nmag = spacing_q - dmag;
        end
        hl = (half_life_q == '0) ? 64'd1 : {32'd0, half_life_q};
        q  = (nmag << 16) / hl;
        // floor split of the exponent into shift and fraction
        if (!nneg || q == '0) begin
            shifts = longint'(q >> 16); frac = q & 64'hFFFF;
        end else if (q[15:0] == '0) begin
            shifts = -longint'(q >> 16); frac = '0;
        end else begin
            shifts = -longint'(q >> 16) - 1; frac = 64'd65536 - (q & 64'hFFFF);
        end
        factor = 64'd65536 + ((K_C1 * frac + K_C2 * frac * frac
                               + K_C3 * frac * frac * frac + K_ROUND) >> 48);
        val = 320'(rq.target) * 320'(factor);
        shifts = shifts - 16;
        if (shifts <= 0) begin
            val = (-shifts >= 320) ? '0 : val >> (-shifts);
        end else begin
            bl = 0;
            for (int i = 319; i >= 0; i--) begin
                if (val[i] && bl == 0) bl = i + 1;
            end
            if (bl != 0 && shifts > longint'(256 - ((bl > 256) ? 256 : bl))) begin
                val = 320'(limit_q); st = ST_LIMITED;
            end else begin
                val = val << shifts;
            end
        end
        if (val[319:256] != '0) begin
            res = limit_q; st = ST_LIMITED;
        end else begin
            res = val[255:0];
        end
        if (res == '0) begin
            res = 256'd1; st = ST_RAISED;
        end else if (res > limit_q) begin
            res = limit_q; st = ST_LIMITED;
        end
        r.next = res; r.status = st; r.bad = bad;
        return r;
    endfunction

    // outcome check; the receiver never stalls, so every strobe is a transfer
    always @(posedge i_clk) begin
        t_adj_res e;
        if (i_rst_n && o_done) begin
            if (pending_targets.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, next=%h", $time,
                         {o_next_w3, o_next_w2, o_next_w1, o_next_w0});
            end else begin
                e = pending_targets.pop_front();
                if ({o_next_w3, o_next_w2, o_next_w1, o_next_w0} !== e.next) begin
                    errors++;
                    $display("%0t: next target expected %h actual %h", $time, e.next,
                             {o_next_w3, o_next_w2, o_next_w1, o_next_w0});
                end
                if (o_clamp_status !== e.status) begin
                    errors++;
                    $display("%0t: clamp_status expected %0d actual %0d", $time,
                             e.status, o_clamp_status);
                end
                if (o_bad_input !== e.bad) begin
                    errors++;
                    $display("%0t: bad_input expected %0b actual %0b", $time,
                             e.bad, o_bad_input);
                end
            end
        end
    end

    // watchdog: cycles with no accepted request and no result
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_SPACING:   spacing_q   = data[31:0];
            REG_HALF_LIFE: half_life_q = data[31:0];
            REG_LIMIT0:    limit_q[63:0]    = data;
            REG_LIMIT1:    limit_q[127:64]  = data;
            REG_LIMIT2:    limit_q[191:128] = data;
            default:       limit_q[255:192] = data;
        endcase
    endtask

    // register changes only with the pipeline drained
    task automatic set_config(input logic [31:0] sp, input logic [31:0] hl,
                              input logic [255:0] lim);
        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        write_reg(REG_SPACING, {32'd0, sp});
        write_reg(REG_HALF_LIFE, {32'd0, hl});
        write_reg(REG_LIMIT0, lim[63:0]);
        write_reg(REG_LIMIT1, lim[127:64]);
        write_reg(REG_LIMIT2, lim[191:128]);
        write_reg(REG_LIMIT3, lim[255:192]);
    endtask

    // present one request and hold it until the transfer; start stays high for the next
    task automatic send_request(input t_adj_req rq, input bit typed, input t_adj_res exp_res);
        {i_ref_target_w3, i_ref_target_w2, i_ref_target_w1, i_ref_target_w0} <= rq.target;
        i_time_diff   <= rq.tdiff;
        i_height_diff <= rq.height;
        start         <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_targets.push_back(typed ? exp_res : adjust_target(rq));
    endtask

    function automatic t_adj_req random_request();
        t_adj_req rq;
        longint   dev;
        int       mode;
        rq.target = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom};
        mode = $urandom_range(0, 9);
        if (mode == 0) rq.target = limit_q;
        else if (mode == 1) rq.target = limit_q - 256'($urandom_range(0, 3));
        else if (mode == 2) rq.target = '0;
        else if (mode != 3) rq.target = rq.target >> $urandom_range(0, 255);
        mode = $urandom_range(0, 9);
        if (mode < 2) begin
            // noise: any time, any height
            rq.tdiff  = {$urandom, $urandom};
            rq.height = 31'($urandom);
        end else begin
            // near the schedule, a few half-lives either way
            rq.height = (mode == 2) ? 31'($urandom) : 31'($urandom_range(0, 1000));
            dev = longint'(half_life_q) * $urandom_range(0, 9) + $urandom_range(0, 65535);
            if ($urandom_range(0, 1)) dev = -dev;
            rq.tdiff = longint'(spacing_q) * (longint'(rq.height) + 1) + dev;
        end
        return rq;
    endfunction

    task automatic random_phase(input int count);
        int left, burst, gap;
        t_adj_res none;
        none = '{'0, ST_NONE, 1'b0};
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < burst && left > 0; i++) begin
                send_request(random_request(), 1'b0, none);
                left--;
            end
            // a zero gap keeps start high into the next burst
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        start <= 1'b0;
    endtask

    initial begin
        t_row      rows[$];
        t_row      row;
        t_adj_res  none;
        logic [255:0] ones;
        none = '{'0, ST_NONE, 1'b0};
        ones = '1;
        spacing_q   = SPACING_RST;
        half_life_q = HALF_LIFE_RST;
        limit_q     = LIM_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // on schedule: exponent zero, target passes through
        rows.push_back('{'{256'd1, 64'd600, 31'd0}, 1'b1, '{256'd1, ST_NONE, 1'b0}});
        // zero reference: flagged and raised to one
        rows.push_back('{'{256'd0, 64'd600, 31'd0}, 1'b1, '{256'd1, ST_RAISED, 1'b1}});
        // reference equal to the limit
        rows.push_back('{'{LIM_RST, 64'd600, 31'd0}, 1'b1, '{LIM_RST, ST_NONE, 1'b0}});
        // reference above the limit: flagged and clamped
        rows.push_back('{'{ones, 64'd600, 31'd0}, 1'b1, '{LIM_RST, ST_LIMITED, 1'b1}});
        // drift bound exceeded upward: huge left shift saturates
        rows.push_back('{'{256'd1, 64'h7FFF_FFFF_FFFF_FFFF, 31'd0}, 1'b1,
                         '{LIM_RST, ST_LIMITED, 1'b1}});
        // drift bound exceeded downward: shifted out, raised to one
        rows.push_back('{'{LIM_RST, 64'h8000_0000_0000_0000, 31'd0}, 1'b1,
                         '{256'd1, ST_RAISED, 1'b1}});
        // one half-life late and early
        rows.push_back('{'{256'd1000, 64'd173400, 31'd0}, 1'b1, '{256'd2000, ST_NONE, 1'b0}});
        rows.push_back('{'{256'd1000, -64'sd172200, 31'd0}, 1'b1, '{256'd500, ST_NONE, 1'b0}});
        // fractional exponents and edge heights through the predictor
        rows.push_back('{'{256'd1 << 200, 64'd50000, 31'd3}, 1'b0, none});
        rows.push_back('{'{256'd12345, -64'sd1, 31'd0}, 1'b0, none});
        rows.push_back('{'{LIM_RST, 64'd0, 31'h7FFF_FFFF}, 1'b0, none});
        rows.push_back('{'{256'hFFFF, 64'd0, 31'd0}, 1'b0, none});
        rows.push_back('{'{LIM_RST >> 1, 64'd1, 31'd1}, 1'b0, none});
        rows.push_back('{'{256'd3, 64'd900_000, 31'd10}, 1'b0, none});
        foreach (rows[i]) begin
            row = rows[i];
            send_request(row.req, row.typed, row.res);
        end
        start <= 1'b0;
        @(posedge i_clk);

        random_phase(300);
        set_config(32'd1, 32'd1, ones);
        random_phase(250);
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, LIM_RST);
        random_phase(250);
        set_config(32'd600, 32'd0, 256'd0);
        random_phase(200);
        set_config(32'd150, 32'd3600, ones >> 32);
        random_phase(300);
        set_config($urandom_range(1, 100000), $urandom_range(1, 1000000),
                   {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom} >> $urandom_range(0, 64));
        random_phase(300);

        while (pending_targets.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
